FILE: hw/rtl/cfr_pkg.sv
`default_nettype none
package cfr_pkg;

    localparam int unsigned BufferDepthDefault = 32;
    localparam int unsigned HdrDepth           = 10;
    localparam int unsigned CountWidth         = 6;
    localparam int unsigned OutDataWidth       = 40;

    localparam logic [7:0] ChStart = 8'h55;
    localparam logic [7:0] ChEnd   = 8'h23;
    localparam logic [7:0] ChQuery = 8'h51;
    localparam logic [7:0] ChRun   = 8'h52;
    localparam logic [7:0] ChWrite = 8'h53;

    localparam logic [7:0] LastLinearIndex = 8'd28;
    localparam logic [7:0] LastIndex       = 8'd34;

    typedef enum logic [1:0] {
        ACT_REJECT = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_RUN    = 2'd2,
        ACT_WRITE  = 2'd3
    } t_action;

    typedef struct packed {
        logic [HdrDepth-1:0][7:0] hdr;
        logic [CountWidth-1:0]    count;
        logic                     ovf;
    } t_frame;

    typedef struct packed {
        t_action     action;
        logic [5:0]  addr;
        logic [23:0] value;
        logic        ovf;
    } t_result;

    // Maps a write index to its device register address; indices above the
    // linear range are remapped and anything past the last index is invalid.
    function automatic logic [6:0] map_index(input logic [7:0] idx);
        logic [6:0] res;
        res = 7'd0;
        if (idx <= LastLinearIndex) begin
            res = {1'b1, idx[5:0]};
        end else begin
            unique case (idx)
                8'd29:   res = {1'b1, 6'd29};
                8'd30:   res = {1'b1, 6'd30};
                8'd31:   res = {1'b1, 6'd33};
                8'd32:   res = {1'b1, 6'd34};
                8'd33:   res = {1'b1, 6'd35};
                8'd34:   res = {1'b1, 6'd32};
                default: res = 7'd0;
            endcase
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/command_frame_receiver.sv
`default_nettype none
// Channel   Dir  Width  Contents
// s_axis    in   8      rx_byte, one serial byte per word
// m_axis    out  40     action, target_address, write_value, overflowed
//
// One byte is taken every cycle while the result path is not blocked.
// Only a '#' byte yields a result, presented on m_axis once it has passed the frame snapshot and the result register.
// The frame snapshot and the result register form a two-deep pipeline;
// s_axis_tready drops only when both hold a result and m_axis_tready is low.
// Reset is synchronous and active low; it empties the frame and both stages.
module command_frame_receiver #(
    parameter int unsigned BUFFER_DEPTH = cfr_pkg::BufferDepthDefault
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [7:0] rx_byte
    input  wire logic [7:0]                         s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [1:0] action, [7:2] target_address, [31:8] write_value,
    // [32] overflowed, [39:33] zero
    output logic [cfr_pkg::OutDataWidth-1:0]        m_axis_tdata
);

    cfr_pkg::t_frame    frame;
    logic               frame_valid;
    logic               advance;
    cfr_pkg::t_result   result;

    cfr_collector #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_collector (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .i_advance     (advance),
        .o_frame       (frame),
        .o_frame_valid (frame_valid)
    );

    cfr_decoder u_decoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (frame),
        .i_frame_valid (frame_valid),
        .o_advance     (advance),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_result      (result)
    );

    assign m_axis_tdata = {7'd0, result.ovf, result.value, result.addr, result.action};

endmodule
`default_nettype wire

FILE: hw/rtl/cfr_collector.sv
`default_nettype none
module cfr_collector #(
    parameter int unsigned BUFFER_DEPTH = cfr_pkg::BufferDepthDefault
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_advance,
    output cfr_pkg::t_frame     o_frame,
    output logic                o_frame_valid
);

    localparam logic [cfr_pkg::CountWidth-1:0] DepthC = cfr_pkg::CountWidth'(BUFFER_DEPTH);

    logic [cfr_pkg::HdrDepth-1:0][7:0]  r_hdr;
    logic [cfr_pkg::CountWidth-1:0]     r_count;
    logic                               r_ovf;
    cfr_pkg::t_frame                    r_snap;
    logic                               r_snap_valid;

    logic [cfr_pkg::HdrDepth-1:0][7:0]  n_hdr;
    logic [cfr_pkg::CountWidth-1:0]     n_count;
    logic                               n_ovf;
    logic                               accept;
    logic                               is_end;

    assign o_ready = !r_snap_valid || i_advance;
    assign accept  = i_valid && o_ready;
    assign is_end  = (i_byte == cfr_pkg::ChEnd);

    always_comb begin
        n_hdr   = r_hdr;
        n_count = r_count;
        n_ovf   = r_ovf;
        if (r_count < DepthC) begin
            for (int i = 0; i < cfr_pkg::HdrDepth; i++) begin
                if (r_count == cfr_pkg::CountWidth'(i)) begin
                    n_hdr[i] = i_byte;
                end
            end
            n_count = r_count + 1'b1;
        end else begin
            n_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr        <= '0;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_snap_valid <= 1'b0;
        end else begin
            if (accept && is_end) begin
                r_hdr        <= '0;
                r_count      <= '0;
                r_ovf        <= 1'b0;
                r_snap_valid <= 1'b1;
            end else begin
                if (accept) begin
                    r_hdr   <= n_hdr;
                    r_count <= n_count;
                    r_ovf   <= n_ovf;
                end
                if (i_advance) begin
                    r_snap_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_end) begin
            r_snap.hdr   <= n_hdr;
            r_snap.count <= n_count;
            r_snap.ovf   <= n_ovf;
        end
    end

    assign o_frame       = r_snap;
    assign o_frame_valid = r_snap_valid;

endmodule
`default_nettype wire

FILE: hw/rtl/cfr_decoder.sv
`default_nettype none
module cfr_decoder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cfr_pkg::t_frame    i_frame,
    input  wire logic               i_frame_valid,
    output logic                    o_advance,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output cfr_pkg::t_result        o_result
);

    logic               r_valid;
    cfr_pkg::t_result   r_result;
    cfr_pkg::t_result   n_result;
    logic [31:0]        stated;
    logic [6:0]         mapped;
    logic               frame_ok;

    assign o_advance = !r_valid || i_ready;
    assign stated    = {i_frame.hdr[5], i_frame.hdr[4], i_frame.hdr[3], i_frame.hdr[2]};
    assign mapped    = cfr_pkg::map_index(i_frame.hdr[6]);
    assign frame_ok  = !i_frame.ovf && (i_frame.hdr[0] == cfr_pkg::ChStart) &&
                       (stated == {{(32 - cfr_pkg::CountWidth){1'b0}}, i_frame.count});

    always_comb begin
        n_result.action = cfr_pkg::ACT_REJECT;
        n_result.addr   = 6'd0;
        n_result.value  = 24'd0;
        n_result.ovf    = i_frame.ovf;
        if (frame_ok) begin
            priority if (i_frame.hdr[1] == cfr_pkg::ChQuery) begin
                n_result.action = cfr_pkg::ACT_QUERY;
            end else if (i_frame.hdr[1] == cfr_pkg::ChRun) begin
                n_result.action = cfr_pkg::ACT_RUN;
            end else if (i_frame.hdr[1] == cfr_pkg::ChWrite && mapped[6]) begin
                n_result.action = cfr_pkg::ACT_WRITE;
                n_result.addr   = mapped[5:0];
                n_result.value  = {i_frame.hdr[9], i_frame.hdr[8], i_frame.hdr[7]};
            end else begin
                n_result.action = cfr_pkg::ACT_REJECT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_frame_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_frame_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire
